// File: rtl/ptq_pkg.sv
package ptq_pkg;

  localparam int PRIO_W  = 8;
  localparam int IDENT_W = 48;
  localparam int COUNT_W = 32;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_TAKE   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE
  } cell_cmd_t;

  typedef struct packed {
    logic               valid;
    logic [PRIO_W-1:0]  prio;
    logic [IDENT_W-1:0] ident;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } chain_stat_t;

endpackage

// File: rtl/ptq_if.sv
interface ptq_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [ptq_pkg::PRIO_W-1:0] task_priority;
  logic                      finish_failed;

  modport source (output valid, output opcode, output task_priority, output finish_failed,
                  input ready);
  modport sink (input valid, input opcode, input task_priority, input finish_failed,
                output ready);
endinterface

interface ptq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [ptq_pkg::IDENT_W-1:0] task_id;
  logic [ptq_pkg::PRIO_W-1:0]  taken_priority;
  logic [ptq_pkg::COUNT_W-1:0] submitted_count;
  logic [ptq_pkg::COUNT_W-1:0] completed_count;
  logic [ptq_pkg::COUNT_W-1:0] failed_count;

  modport source (output valid, output status, output task_id, output taken_priority,
                  output submitted_count, output completed_count, output failed_count,
                  input ready);
  modport sink (input valid, input status, input task_id, input taken_priority,
                input submitted_count, input completed_count, input failed_count,
                output ready);
endinterface

// File: rtl/ptq_cell.sv
module ptq_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  ptq_pkg::cell_cmd_t         cmd,
  input  ptq_pkg::entry_t            new_entry,
  input  ptq_pkg::entry_t            left,
  input  logic                       left_ins,
  input  ptq_pkg::entry_t            right,
  output logic                       ins,
  output ptq_pkg::entry_t            q
);
  import ptq_pkg::*;

  entry_t q_next;

  assign ins = !q.valid || (new_entry.prio >= q.prio);

  always_comb begin
    q_next = q;
    unique case (cmd)
      CMD_INSERT: begin
        if (ins) begin
          q_next = left_ins ? left : new_entry;
        end
      end
      CMD_REMOVE: q_next = right;
      default:    q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= q_next.valid;
    end
    q.prio  <= q_next.prio;
    q.ident <= q_next.ident;
  end

endmodule

// File: rtl/ptq_chain.sv
module ptq_chain #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ptq_pkg::cell_cmd_t    cmd,
  input  ptq_pkg::entry_t       new_entry,
  output ptq_pkg::entry_t       head,
  output ptq_pkg::chain_stat_t  stat
);
  import ptq_pkg::*;

  entry_t q   [QUEUE_DEPTH];
  logic   ins [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left;
    entry_t right;
    logic   left_ins;

    if (i == 0) begin : g_first
      assign left     = '0;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left     = q[i-1];
      assign left_ins = ins[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = q[i+1];
    end

    ptq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .new_entry (new_entry),
      .left      (left),
      .left_ins  (left_ins),
      .right     (right),
      .ins       (ins[i]),
      .q         (q[i])
    );
  end

  assign head       = q[0];
  assign stat.full  = q[QUEUE_DEPTH-1].valid;
  assign stat.empty = !q[0].valid;

  for (genvar i = 1; i < QUEUE_DEPTH; i++) begin : g_chk
    a_prefix: assert property (@(posedge clk) disable iff (rst)
      q[i].valid |-> q[i-1].valid)
      else $error("valid entries not contiguous");
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      q[i].valid |-> (q[i-1].prio >= q[i].prio))
      else $error("chain out of priority order");
  end

endmodule

// File: rtl/priority_task_queue.sv
// A result is registered in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; an unread result
// holds off the next item.
// Reset clears every cell's valid bit, all counters and sets the next
// identifier to one; no clearing pass is needed.
module priority_task_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  ptq_req_if.sink        req,
  ptq_rsp_if.source      rsp
);
  import ptq_pkg::*;

  cell_cmd_t           cmd;
  entry_t              new_entry;
  entry_t              head;
  chain_stat_t         stat;
  logic                accept;

  logic [IDENT_W-1:0]  next_ident;
  logic [IDENT_W-1:0]  next_ident_next;
  logic [COUNT_W-1:0]  submitted_total;
  logic [COUNT_W-1:0]  submitted_total_next;
  logic [COUNT_W-1:0]  completed_total;
  logic [COUNT_W-1:0]  completed_total_next;
  logic [COUNT_W-1:0]  failed_total;
  logic [COUNT_W-1:0]  failed_total_next;
  logic [1:0]          status_next;
  logic [IDENT_W-1:0]  id_next;
  logic [PRIO_W-1:0]   tprio_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign new_entry.valid = 1'b1;
  assign new_entry.prio  = req.task_priority;
  assign new_entry.ident = next_ident;

  always_comb begin
    cmd                  = CMD_HOLD;
    status_next          = ST_OK;
    id_next              = '0;
    tprio_next           = '0;
    next_ident_next      = next_ident;
    submitted_total_next = submitted_total;
    completed_total_next = completed_total;
    failed_total_next    = failed_total;
    if (accept) begin
      unique case (req.opcode)
        OP_SUBMIT: begin
          if (stat.full) begin
            status_next = ST_FULL;
          end else begin
            cmd             = CMD_INSERT;
            id_next         = next_ident;
            next_ident_next = (&next_ident) ? next_ident : next_ident + IDENT_W'(1);
            submitted_total_next = (&submitted_total) ? submitted_total
                                                      : submitted_total + COUNT_W'(1);
          end
        end
        OP_TAKE: begin
          if (stat.empty) begin
            status_next = ST_EMPTY;
          end else begin
            cmd        = CMD_REMOVE;
            id_next    = head.ident;
            tprio_next = head.prio;
          end
        end
        OP_FINISH: begin
          if (req.finish_failed) begin
            failed_total_next = (&failed_total) ? failed_total
                                                : failed_total + COUNT_W'(1);
          end else begin
            completed_total_next = (&completed_total) ? completed_total
                                                      : completed_total + COUNT_W'(1);
          end
        end
        default: cmd = CMD_HOLD;
      endcase
    end
  end

  ptq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .new_entry (new_entry),
    .head      (head),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      next_ident      <= IDENT_W'(1);
      submitted_total <= '0;
      completed_total <= '0;
      failed_total    <= '0;
      rsp.valid       <= 1'b0;
    end else begin
      next_ident      <= next_ident_next;
      submitted_total <= submitted_total_next;
      completed_total <= completed_total_next;
      failed_total    <= failed_total_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status          <= status_next;
      rsp.task_id         <= id_next;
      rsp.taken_priority  <= tprio_next;
      rsp.submitted_count <= submitted_total_next;
      rsp.completed_count <= completed_total_next;
      rsp.failed_count    <= failed_total_next;
    end
  end

  a_not_full_and_empty: assert property (@(posedge clk) disable iff (rst)
    !(stat.full && stat.empty))
    else $error("queue both full and empty");

  a_submit_id: assert property (@(posedge clk) disable iff (rst)
    (accept && req.opcode == OP_SUBMIT && !stat.full)
      |=> (rsp.valid && rsp.status == ST_OK && rsp.task_id != '0))
    else $error("accepted submit without identifier");

  a_take_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && req.opcode == OP_TAKE && stat.empty)
      |=> (rsp.status == ST_EMPTY && rsp.task_id == '0 && rsp.taken_priority == '0))
    else $error("take from empty queue returned an entry");

  a_ident_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_ident != '0)
    else $error("identifier counter wrapped");

endmodule

// File: test/tb_priority_task_queue.sv
`timescale 1ns / 100ps

module tb_priority_task_queue;
  import ptq_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [IDENT_W-1:0] IDENT_TOP = '1;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 95;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [1:0]         status;
    logic [IDENT_W-1:0] task_id;
    logic [PRIO_W-1:0]  prio;
    logic [COUNT_W-1:0] submitted;
    logic [COUNT_W-1:0] completed;
    logic [COUNT_W-1:0] failed;
  } task_result_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [PRIO_W-1:0] prio;
    logic              failed;
    logic              typed;
    task_result_t      result;
  } task_item_t;

  logic clk;
  logic rst;

  ptq_req_if req ();
  ptq_rsp_if rsp ();

  priority_task_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic [PRIO_W-1:0]  shadow_prio  [DEPTH];
  logic [IDENT_W-1:0] shadow_ident [DEPTH];
  int                 shadow_fill;
  logic [IDENT_W-1:0] shadow_next_id;
  logic [COUNT_W-1:0] shadow_submitted;
  logic [COUNT_W-1:0] shadow_completed;
  logic [COUNT_W-1:0] shadow_failed;

  task_item_t   offered_items [$];
  task_item_t   directed_items [$];
  task_result_t pending_results [$];

  int errors;
  bit quiet;
  bit hold_off_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic task_result_t serve_request(task_item_t it);
    task_result_t r;
    int i;
    int best;
    r = '0;
    r.status = ST_OK;
    case (it.opcode)
      OP_SUBMIT: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = DEPTH - 1; i > 0; i--) begin
            shadow_prio[i]  = shadow_prio[i-1];
            shadow_ident[i] = shadow_ident[i-1];
          end
          shadow_prio[0]  = it.prio;
          shadow_ident[0] = shadow_next_id;
          r.task_id = shadow_next_id;
          if (shadow_next_id != IDENT_TOP) shadow_next_id++;
          if (shadow_submitted != COUNT_TOP) shadow_submitted++;
          shadow_fill++;
        end
      end
      OP_TAKE: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          best = 0;
          for (i = 1; i < shadow_fill; i++)
            if (shadow_prio[i] > shadow_prio[best]) best = i;
          r.task_id = shadow_ident[best];
          r.prio    = shadow_prio[best];
          for (i = best; i < DEPTH - 1; i++) begin
            shadow_prio[i]  = shadow_prio[i+1];
            shadow_ident[i] = shadow_ident[i+1];
          end
          shadow_fill--;
        end
      end
      OP_FINISH: begin
        if (it.failed) begin
          if (shadow_failed != COUNT_TOP) shadow_failed++;
        end else begin
          if (shadow_completed != COUNT_TOP) shadow_completed++;
        end
      end
      default: ;
    endcase
    r.submitted = shadow_submitted;
    r.completed = shadow_completed;
    r.failed    = shadow_failed;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got_v, logic [63:0] exp_v);
    if (errors < 50)
      $display("%0t mismatch %s: got %0h, want %0h", $time, what, got_v, exp_v);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic task_item_t make_item(logic [1:0] op, logic [PRIO_W-1:0] prio,
                                           logic failed);
    task_item_t it;
    it = '0;
    it.opcode = op;
    it.prio   = prio;
    it.failed = failed;
    return it;
  endfunction

  function automatic void add_row(logic [1:0] op, logic [PRIO_W-1:0] prio, logic failed);
    directed_items.push_back(make_item(op, prio, failed));
  endfunction

  function automatic void add_typed(logic [1:0] op, logic [PRIO_W-1:0] prio, logic failed,
                                    logic [1:0] status, logic [IDENT_W-1:0] id,
                                    logic [PRIO_W-1:0] tprio, logic [COUNT_W-1:0] sub,
                                    logic [COUNT_W-1:0] comp, logic [COUNT_W-1:0] fail);
    task_item_t it;
    it = make_item(op, prio, failed);
    it.typed = 1'b1;
    it.result.status    = status;
    it.result.task_id   = id;
    it.result.prio      = tprio;
    it.result.submitted = sub;
    it.result.completed = comp;
    it.result.failed    = fail;
    directed_items.push_back(it);
  endfunction

  task automatic send_request(task_item_t it);
    int gap;
    offered_items.push_back(it);
    req.valid         <= 1'b1;
    req.opcode        <= it.opcode;
    req.task_priority <= it.prio;
    req.finish_failed <= it.failed;
    do @(posedge clk); while (!req.ready);
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin : result_check
    task_item_t   it;
    task_result_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        if (offered_items.size() == 0) begin
          report_mismatch("item accepted that was never offered", 0, 0);
        end else begin
          it = offered_items.pop_front();
          want = serve_request(it);
          if (it.typed) want = it.result;
          pending_results.push_back(want);
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", rsp.task_id, 0);
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
          if (rsp.task_id !== want.task_id)
            report_mismatch("task_id", rsp.task_id, want.task_id);
          if (rsp.taken_priority !== want.prio)
            report_mismatch("taken_priority", rsp.taken_priority, want.prio);
          if (rsp.submitted_count !== want.submitted)
            report_mismatch("submitted_count", rsp.submitted_count, want.submitted);
          if (rsp.completed_count !== want.completed)
            report_mismatch("completed_count", rsp.completed_count, want.completed);
          if (rsp.failed_count !== want.failed)
            report_mismatch("failed_count", rsp.failed_count, want.failed);
        end
      end
    end
  end

  initial begin : ready_drive
    int run_left;
    int gap_left;
    int hold_left;
    rsp.ready = 1'b0;
    run_left  = 0;
    gap_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (rst || hold_left > 0 || gap_left > 0) begin
        rsp.ready <= 1'b0;
        if (hold_left > 0) hold_left--;
        else if (gap_left > 0) gap_left--;
      end else begin
        rsp.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left = $urandom_range(1, 16);
          gap_left = pick_gap();
        end
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int r;
    int kind;
    int sub_pct;
    int take_pct;
    logic [1:0] op;
    logic [PRIO_W-1:0] prio;

    errors       = 0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    shadow_fill      = 0;
    shadow_next_id   = 1;
    shadow_submitted = '0;
    shadow_completed = '0;
    shadow_failed    = '0;
    for (n = 0; n < DEPTH; n++) begin
      shadow_prio[n]  = '0;
      shadow_ident[n] = '0;
    end

    req.valid         = 1'b0;
    req.opcode        = OP_SUBMIT;
    req.task_priority = '0;
    req.finish_failed = 1'b0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    add_typed(OP_TAKE,   8'hff, 1'b1, ST_EMPTY, 0, 0,     0, 0, 0);
    add_typed(OP_FINISH, 8'h00, 1'b0, ST_OK,    0, 0,     0, 1, 0);
    add_typed(OP_FINISH, 8'hff, 1'b1, ST_OK,    0, 0,     0, 1, 1);
    add_typed(OP_SPARE,  8'hff, 1'b1, ST_OK,    0, 0,     0, 1, 1);
    add_typed(OP_SUBMIT, 8'h00, 1'b1, ST_OK,    1, 0,     1, 1, 1);
    add_typed(OP_SUBMIT, 8'hff, 1'b0, ST_OK,    2, 0,     2, 1, 1);
    add_typed(OP_SUBMIT, 8'hff, 1'b0, ST_OK,    3, 0,     3, 1, 1);
    add_typed(OP_TAKE,   8'h00, 1'b0, ST_OK,    3, 8'hff, 3, 1, 1);
    add_row(OP_SUBMIT, 8'd10,  1'b0);
    add_row(OP_SUBMIT, 8'd200, 1'b1);
    add_row(OP_SUBMIT, 8'd200, 1'b0);
    add_row(OP_SUBMIT, 8'd0,   1'b0);
    add_row(OP_SUBMIT, 8'd255, 1'b1);
    add_row(OP_SUBMIT, 8'd1,   1'b0);
    add_row(OP_SUBMIT, 8'd128, 1'b0);
    add_row(OP_SUBMIT, 8'd127, 1'b1);
    add_row(OP_SUBMIT, 8'd254, 1'b0);
    add_row(OP_SUBMIT, 8'd7,   1'b0);
    add_row(OP_SUBMIT, 8'd7,   1'b1);
    add_row(OP_SUBMIT, 8'd64,  1'b0);
    add_row(OP_SUBMIT, 8'd99,  1'b0);
    add_row(OP_SUBMIT, 8'd3,   1'b0);
    add_typed(OP_SUBMIT, 8'h80, 1'b1, ST_FULL, 0, 0, 17, 1, 1);
    add_row(OP_TAKE, 8'h55, 1'b1);

    foreach (directed_items[i]) send_request(directed_items[i]);
    wait_for_results();

    for (phase = 0; phase < PHASES; phase++) begin
      kind  = phase % 4;
      quiet = ($urandom_range(0, 3) == 0);
      case (kind)
        0:       begin sub_pct = 70; take_pct = 88; end
        1:       begin sub_pct = 25; take_pct = 85; end
        default: begin sub_pct = 48; take_pct = 92; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 10 && (phase == 2 || $urandom_range(0, 4) == 0)) hold_off_req = 1'b1;
        r = $urandom_range(0, 99);
        if (r < sub_pct)       op = OP_SUBMIT;
        else if (r < take_pct) op = OP_TAKE;
        else if (r < 98)       op = OP_FINISH;
        else                   op = OP_SPARE;
        r = $urandom_range(0, 9);
        if (kind == 3)   prio = 8'($urandom_range(0, 2) * 127);
        else if (r == 0) prio = $urandom_range(0, 1) ? 8'hff : 8'h00;
        else             prio = 8'($urandom_range(0, 255));
        send_request(make_item(op, prio, 1'($urandom_range(0, 1))));
      end
      if (phase == 5 || $urandom_range(0, 3) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ptq_pkg.sv
rtl/ptq_if.sv
rtl/ptq_cell.sv
rtl/ptq_chain.sv
rtl/priority_task_queue.sv
test/tb_priority_task_queue.sv
